// ===== hw/rtl/dpwo_pkg.sv =====
// ---------------------------------------------------------------------------
// dpwo_pkg
// Shared types, constants and the octave root table for the dual pulse
// width oscillator.
// ---------------------------------------------------------------------------
`default_nettype none

package dpwo_pkg;

   localparam int PHASE_BITS_DEF    = 32;
   localparam int LANES             = 2;

   localparam int CV_BITS           = 16;
   localparam int REQ_BITS          = 64;
   localparam int RSP_BITS          = 8;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 32;

   // Pitch: Q.12 octaves, saturated to +-12 octaves
   localparam int OCT_FRAC_BITS     = 12;
   localparam int OCT_MAX           = 12;
   localparam logic signed [17:0] PITCH_SAT = 18'sd49152;

   // Exponent table resolution (power of two)
   localparam int EXP_TABLE_ENTRIES = 1024;
   localparam int EXP_IDX_BITS      = $clog2(EXP_TABLE_ENTRIES);
   localparam logic [OCT_FRAC_BITS-1:0] EXP_FRAC_MASK =
      OCT_FRAC_BITS'(12'hFFF << (OCT_FRAC_BITS - EXP_IDX_BITS));
   localparam int EXP_STEPS         = OCT_FRAC_BITS;
   localparam logic [31:0] EXP_ONE  = 32'h8000_0000;
   localparam int PROD_TOP          = 63;

   // Duty: d = knob + trunc(cv * 16 / 5), clamped
   localparam logic [19:0] DUTY_RECIP = 20'd838861;
   localparam int DUTY_SHIFT        = 18;
   localparam logic signed [18:0] DUTY_MIN = 19'sd655;
   localparam logic signed [18:0] DUTY_MAX = 19'sd64880;

   // Pipeline stage map
   localparam int STG_FRONT         = 0;
   localparam int STG_EXP0          = 1;
   localparam int STG_MUL           = STG_EXP0 + EXP_STEPS;
   localparam int STG_SHIFT         = STG_MUL + 1;
   localparam int STG_OUT           = STG_SHIFT + 1;
   localparam int PIPE_DEPTH        = STG_OUT + 1;

   // Register reset values
   localparam logic [31:0]        BASE_INC_RST   = 32'd23409854;
   localparam logic signed [15:0] PITCH_KNOB_RST = 16'sd0;
   localparam logic [15:0]        DUTY_KNOB_RST  = 16'd32768;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_INC     = 3'd0,
      CSR_PITCH_KNOB_A = 3'd1,
      CSR_PITCH_KNOB_B = 3'd2,
      CSR_DUTY_KNOB_A  = 3'd3,
      CSR_DUTY_KNOB_B  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PIPE_DEPTH-1:0] adv;
   } pipe_ctl_type;

   typedef logic [EXP_STEPS-1:0][31:0] root_vec_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] rem;
      r   = '0;
      rem = x;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Root k is 2^(2^-(k+1)) in Q.31
   function automatic root_vec_type exp_roots();
      root_vec_type rv;
      logic [63:0]  cur;
      cur = isqrt64(64'd1 << 63);
      rv[0] = cur[31:0];
      for (int k = 1; k < EXP_STEPS; k++) begin
         cur   = isqrt64({cur[32:0], 31'd0});
         rv[k] = cur[31:0];
      end
      return rv;
   endfunction

   localparam root_vec_type EXP_ROOTS = exp_roots();

endpackage

`default_nettype wire

// ===== hw/rtl/dpwo_ctrl.sv =====
// ---------------------------------------------------------------------------
// dpwo_ctrl
// Stage valid tracking and per-stage advance enables shared by all lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module dpwo_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output dpwo_pkg::pipe_ctl_type ctl
);

   localparam int DEPTH = dpwo_pkg::PIPE_DEPTH;

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [DEPTH-1:0] rdy;
   logic [DEPTH-1:0] hold;
   logic [DEPTH-1:0] adv;

   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      assign rdy[i] = rsp_tready | ~(&valid_ff[DEPTH-1:i]);
      if (i == 0) begin : g_first
         assign adv[i] = req_tvalid & rdy[i];
      end else begin : g_mid
         assign adv[i] = valid_ff[i-1] & rdy[i];
      end
      if (i == DEPTH-1) begin : g_last
         assign hold[i] = ~rsp_tready;
      end else begin : g_inner
         assign hold[i] = ~rdy[i+1];
      end
      assign valid_in[i] = adv[i] | (valid_ff[i] & hold[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.adv    = adv;
   assign req_tready = rdy[0];
   assign rsp_tvalid = valid_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== hw/rtl/dpwo_lane.sv =====
// ---------------------------------------------------------------------------
// dpwo_lane
// One oscillator channel: pitch saturation, 2^pitch by a chain of root
// multiplies, increment shift, phase accumulation and duty compare.
// ---------------------------------------------------------------------------
`default_nettype none

module dpwo_lane #(
   parameter int PHASE_BITS = dpwo_pkg::PHASE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dpwo_pkg::pipe_ctl_type ctl,
   input  logic [31:0]            base_increment,
   input  logic signed [15:0]     pitch_knob,
   input  logic [15:0]            duty_knob,
   input  logic signed [15:0]     pitch_cv,
   input  logic signed [15:0]     duty_cv,
   output logic                   level
);

   localparam int STEPS      = dpwo_pkg::EXP_STEPS;
   localparam int FB         = dpwo_pkg::OCT_FRAC_BITS;
   localparam int SHIFT_BASE = dpwo_pkg::PROD_TOP + dpwo_pkg::OCT_MAX - PHASE_BITS;

   // Front stage
   logic signed [17:0] p_sum;
   logic signed [17:0] p_sat;
   logic [16:0]        p_off;
   logic signed [16:0] dcv_ext;
   logic [16:0]        dmag;
   logic [36:0]        dprod;

   logic [4:0]         nidx_ff [0:dpwo_pkg::STG_MUL];
   logic [FB-1:0]      g_ff    [0:STEPS-1];
   logic [36:0]        dprod_ff;
   logic               dneg_ff;

   // Later stages
   logic [31:0]        v_ff    [1:STEPS];
   logic [15:0]        d_ff    [1:dpwo_pkg::STG_SHIFT];
   logic [63:0]        prod_ff;
   logic [PHASE_BITS-1:0] inc_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] thresh;

   logic [16:0]        dq_mag;
   logic signed [18:0] dq;
   logic signed [18:0] dsum;
   logic [15:0]        d_clamp;
   logic [6:0]         sh;

   always_comb begin
      p_sum = 18'(pitch_knob) + 18'(pitch_cv) + 18'(pitch_cv);
      priority if (p_sum > dpwo_pkg::PITCH_SAT) begin
         p_sat = dpwo_pkg::PITCH_SAT;
      end else if (p_sum < -dpwo_pkg::PITCH_SAT) begin
         p_sat = -dpwo_pkg::PITCH_SAT;
      end else begin
         p_sat = p_sum;
      end
      p_off   = 17'(p_sat + dpwo_pkg::PITCH_SAT);
      dcv_ext = 17'(duty_cv);
      dmag    = duty_cv[15] ? 17'(-dcv_ext) : 17'(dcv_ext);
      dprod   = 37'(dmag) * 37'(dpwo_pkg::DUTY_RECIP);
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[dpwo_pkg::STG_FRONT]) begin
         nidx_ff[0] <= p_off[16:FB];
         g_ff[0]    <= p_off[FB-1:0] & dpwo_pkg::EXP_FRAC_MASK;
         dprod_ff   <= dprod;
         dneg_ff    <= duty_cv[15];
      end
   end

   // Duty finish, alongside the first exponent step
   always_comb begin
      dq_mag = 17'(dprod_ff >> dpwo_pkg::DUTY_SHIFT);
      dq     = dneg_ff ? -(19'(dq_mag)) : 19'(dq_mag);
      dsum   = 19'(duty_knob) + dq;
      priority if (dsum > dpwo_pkg::DUTY_MAX) begin
         d_clamp = 16'(dpwo_pkg::DUTY_MAX);
      end else if (dsum < dpwo_pkg::DUTY_MIN) begin
         d_clamp = 16'(dpwo_pkg::DUTY_MIN);
      end else begin
         d_clamp = 16'(dsum);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[dpwo_pkg::STG_EXP0]) begin
         d_ff[1] <= d_clamp;
      end
   end

   for (genvar s = 2; s <= dpwo_pkg::STG_SHIFT; s++) begin : g_dcarry
      always_ff @(posedge clock) begin
         if (ctl.adv[s]) begin
            d_ff[s] <= d_ff[s-1];
         end
      end
   end

   for (genvar s = 1; s <= dpwo_pkg::STG_MUL; s++) begin : g_ncarry
      always_ff @(posedge clock) begin
         if (ctl.adv[s]) begin
            nidx_ff[s] <= nidx_ff[s-1];
         end
      end
   end

   // Multiply in one octave root per set fraction bit
   for (genvar k = 0; k < STEPS; k++) begin : g_exp
      logic [31:0] v_prev;
      logic [63:0] v_mul;
      if (k == 0) begin : g_seed
         assign v_prev = dpwo_pkg::EXP_ONE;
      end else begin : g_chain
         assign v_prev = v_ff[k];
      end
      assign v_mul = 64'(v_prev) * 64'(dpwo_pkg::EXP_ROOTS[k]);
      always_ff @(posedge clock) begin
         if (ctl.adv[dpwo_pkg::STG_EXP0 + k]) begin
            v_ff[k+1] <= g_ff[k][FB-1-k] ? v_mul[62:31] : v_prev;
         end
      end
      if (k < STEPS-1) begin : g_gcarry
         always_ff @(posedge clock) begin
            if (ctl.adv[dpwo_pkg::STG_EXP0 + k]) begin
               g_ff[k+1] <= g_ff[k];
            end
         end
      end
   end

   assign sh = 7'(SHIFT_BASE) - 7'(nidx_ff[dpwo_pkg::STG_MUL]);

   always_ff @(posedge clock) begin
      if (ctl.adv[dpwo_pkg::STG_MUL]) begin
         prod_ff <= 64'(v_ff[STEPS]) * 64'(base_increment);
      end
      if (ctl.adv[dpwo_pkg::STG_SHIFT]) begin
         inc_ff <= PHASE_BITS'(prod_ff >> sh);
      end
   end

   assign phase_in = phase_ff + inc_ff;
   assign thresh   = PHASE_BITS'(d_ff[dpwo_pkg::STG_SHIFT]) << (PHASE_BITS - 16);
   assign level    = (phase_in < thresh);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (ctl.adv[dpwo_pkg::STG_OUT]) begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dpwo_merge.sv =====
// ---------------------------------------------------------------------------
// dpwo_merge
// Output register: packs the lane levels into one result item.
// ---------------------------------------------------------------------------
`default_nettype none

module dpwo_merge (
   input  logic                          clock,
   input  dpwo_pkg::pipe_ctl_type        ctl,
   input  logic [dpwo_pkg::LANES-1:0]    lane_level,
   output logic [dpwo_pkg::RSP_BITS-1:0] rsp_tdata
);

   logic [dpwo_pkg::RSP_BITS-1:0] tdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.adv[dpwo_pkg::STG_OUT]) begin
         tdata_ff <= dpwo_pkg::RSP_BITS'(lane_level);
      end
   end

   assign rsp_tdata = tdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_pulse_width_oscillator_unit.sv =====
// ---------------------------------------------------------------------------
// dual_pulse_width_oscillator_unit
// Two pulse-width oscillators with volt-per-octave pitch and PWM inputs,
// one sample tick per item.
//
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    req_tdata  (64b, four CVs)
// rsp      out  rsp_tvalid/tready    rsp_tdata  (8b, two levels)
// csr      in   csr_valid/ready      csr_index, csr_data
//
// One item per cycle sustained while rsp_tready is high.
// Latency is set by the 12-step root multiply chain that forms 2^pitch.
// Synchronous reset clears both phases and all stage valids and returns the registers to their reset values.
// req_tready drops only when all 16 stages hold items and rsp_tready is low.
// csr_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_pulse_width_oscillator_unit #(
   parameter int PHASE_BITS = dpwo_pkg::PHASE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] pitch_cv_a, [31:16] duty_cv_a, [47:32] pitch_cv_b, [63:48] duty_cv_b
   input  logic [dpwo_pkg::REQ_BITS-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] level_a, [1] level_b, [7:2] zero
   output logic [dpwo_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dpwo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dpwo_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic [31:0]        base_inc_ff;
   logic signed [15:0] pitch_knob_a_ff;
   logic signed [15:0] pitch_knob_b_ff;
   logic [15:0]        duty_knob_a_ff;
   logic [15:0]        duty_knob_b_ff;

   dpwo_pkg::pipe_ctl_type       ctl;
   logic [dpwo_pkg::LANES-1:0]   lane_level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_inc_ff     <= dpwo_pkg::BASE_INC_RST;
         pitch_knob_a_ff <= dpwo_pkg::PITCH_KNOB_RST;
         pitch_knob_b_ff <= dpwo_pkg::PITCH_KNOB_RST;
         duty_knob_a_ff  <= dpwo_pkg::DUTY_KNOB_RST;
         duty_knob_b_ff  <= dpwo_pkg::DUTY_KNOB_RST;
      end else if (csr_valid) begin
         unique case (dpwo_pkg::csr_index_type'(csr_index))
            dpwo_pkg::CSR_BASE_INC:     base_inc_ff     <= csr_data[31:0];
            dpwo_pkg::CSR_PITCH_KNOB_A: pitch_knob_a_ff <= csr_data[15:0];
            dpwo_pkg::CSR_PITCH_KNOB_B: pitch_knob_b_ff <= csr_data[15:0];
            dpwo_pkg::CSR_DUTY_KNOB_A:  duty_knob_a_ff  <= csr_data[15:0];
            dpwo_pkg::CSR_DUTY_KNOB_B:  duty_knob_b_ff  <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   dpwo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   dpwo_lane #(.PHASE_BITS(PHASE_BITS)) u_lane_a (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .base_increment (base_inc_ff),
      .pitch_knob     (pitch_knob_a_ff),
      .duty_knob      (duty_knob_a_ff),
      .pitch_cv       (req_tdata[15:0]),
      .duty_cv        (req_tdata[31:16]),
      .level          (lane_level[0])
   );

   dpwo_lane #(.PHASE_BITS(PHASE_BITS)) u_lane_b (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .base_increment (base_inc_ff),
      .pitch_knob     (pitch_knob_b_ff),
      .duty_knob      (duty_knob_b_ff),
      .pitch_cv       (req_tdata[47:32]),
      .duty_cv        (req_tdata[63:48]),
      .level          (lane_level[1])
   );

   dpwo_merge u_merge (
      .clock      (clock),
      .ctl        (ctl),
      .lane_level (lane_level),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/dpwo_checker.sv =====
// ---------------------------------------------------------------------------
// dpwo_checker
// Port-level checks for the dual pulse width oscillator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module dpwo_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dpwo_pkg::RSP_BITS-1:0]       rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[dpwo_pkg::RSP_BITS-1:dpwo_pkg::LANES] == '0)
      else $error("result padding bits not zero");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while output side is free");

endmodule

bind dual_pulse_width_oscillator_unit dpwo_checker u_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual pulse width oscillator. A clocked driver
// streams control-voltage items from a backlog queue. A clocked monitor
// forecasts both channel levels for every sample tick it sees accepted and
// checks each returned item against the oldest forecast. Register settings
// change between phases, with the block idle. Both sides idle at random, and
// one phase holds the output off long enough to fill the pipeline.
// ---------------------------------------------------------------------------

module testbench;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 24;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS     = 150;
   localparam int IDLE_PCT        = 38;
   localparam int ACC_BITS        = dpwo_pkg::PHASE_BITS_DEF;
   localparam int FRAC_BITS       = dpwo_pkg::OCT_FRAC_BITS;
   localparam int TABLE_ENTRIES   = dpwo_pkg::EXP_TABLE_ENTRIES;
   localparam int INDEX_BITS      = dpwo_pkg::CSR_INDEX_BITS;
   localparam int DATA_BITS       = dpwo_pkg::CSR_DATA_BITS;
   localparam logic [INDEX_BITS-1:0] CSR_SPARE_LOW = 3'd5;
   localparam logic [INDEX_BITS-1:0] CSR_SPARE_TOP = 3'd7;

   typedef struct packed {
      logic signed [15:0] duty_cv_b;
      logic signed [15:0] pitch_cv_b;
      logic signed [15:0] duty_cv_a;
      logic signed [15:0] pitch_cv_a;
   } cv_item_type;

   typedef struct packed {
      logic level_b;
      logic level_a;
   } level_pair_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   cv_item_type                   req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [dpwo_pkg::RSP_BITS-1:0] rsp_tdata;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [INDEX_BITS-1:0]         csr_index  = '0;
   logic [DATA_BITS-1:0]          csr_data   = '0;

   // forecast model of the block
   logic [31:0]         base_step;
   logic signed [15:0]  pitch_offset [2];
   logic [15:0]         width_knob [2];
   logic [ACC_BITS-1:0] phase_acc [2];
   logic [31:0]         pow2_frac [TABLE_ENTRIES];

   cv_item_type    cv_backlog[$];
   level_pair_type level_forecast[$];

   int items_queued    = 0;
   int items_taken     = 0;
   int results_seen    = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;
   int idle_pct        = IDLE_PCT;
   int rsp_holds_asked = 0;
   int rsp_holds_done  = 0;
   int hold_left       = 0;
   bit req_took        = 1'b0;

   dual_pulse_width_oscillator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [127:0] trial;
      logic [63:0]  r;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = 128'(r | (64'd1 << b));
         if (trial * trial <= 128'(x)) r = r | (64'd1 << b);
      end
      return r;
   endfunction

   // entry i holds 2^(i / TABLE_ENTRIES) in Q.31, built from square roots
   function automatic void build_pow2_table();
      logic [63:0] root [FRAC_BITS];
      logic [95:0] acc;
      int          g;
      root[0] = floor_root(64'd1 << 63);
      for (int k = 1; k < FRAC_BITS; k++) root[k] = floor_root(root[k-1] << 31);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         g   = (i * (1 << FRAC_BITS)) / TABLE_ENTRIES;
         acc = 96'd1 << 31;
         for (int k = 0; k < FRAC_BITS; k++)
            if (g[FRAC_BITS-1-k]) acc = (acc * 96'(root[k])) >> 31;
         pow2_frac[i] = acc[31:0];
      end
   endfunction

   function automatic void restore_power_on();
      base_step = dpwo_pkg::BASE_INC_RST;
      for (int ch = 0; ch < 2; ch++) begin
         pitch_offset[ch] = dpwo_pkg::PITCH_KNOB_RST;
         width_knob[ch]   = dpwo_pkg::DUTY_KNOB_RST;
         phase_acc[ch]    = '0;
      end
   endfunction

   function automatic void load_register(input logic [INDEX_BITS-1:0] index,
                                         input logic [DATA_BITS-1:0] value);
      case (index)
         dpwo_pkg::CSR_BASE_INC:     base_step       = value;
         dpwo_pkg::CSR_PITCH_KNOB_A: pitch_offset[0] = value[15:0];
         dpwo_pkg::CSR_PITCH_KNOB_B: pitch_offset[1] = value[15:0];
         dpwo_pkg::CSR_DUTY_KNOB_A:  width_knob[0]   = value[15:0];
         dpwo_pkg::CSR_DUTY_KNOB_B:  width_knob[1]   = value[15:0];
         default: ;
      endcase
   endfunction

   function automatic logic advance_voice(input int ch, input logic signed [15:0] pitch_cv,
                                          input logic signed [15:0] duty_cv);
      int          octaves;
      int          biased;
      int          whole;
      int          pulse_w;
      int          sat;
      logic [95:0] product;
      sat     = int'(dpwo_pkg::PITCH_SAT);
      octaves = int'(pitch_offset[ch]) + 2 * int'(pitch_cv);
      if (octaves > sat) octaves = sat;
      if (octaves < -sat) octaves = -sat;
      biased  = octaves + sat;
      whole   = (biased >> FRAC_BITS) - dpwo_pkg::OCT_MAX;
      product = 96'(base_step) * 96'(pow2_frac[((biased & ((1 << FRAC_BITS) - 1))
                * TABLE_ENTRIES) >> FRAC_BITS]);
      phase_acc[ch] = phase_acc[ch] + ACC_BITS'(product >> (63 - ACC_BITS - whole));
      pulse_w = int'(width_knob[ch]) + (int'(duty_cv) * 16) / 5;
      if (pulse_w > int'(dpwo_pkg::DUTY_MAX)) pulse_w = int'(dpwo_pkg::DUTY_MAX);
      if (pulse_w < int'(dpwo_pkg::DUTY_MIN)) pulse_w = int'(dpwo_pkg::DUTY_MIN);
      return phase_acc[ch] < (ACC_BITS'(pulse_w) << (ACC_BITS - 16));
   endfunction

   function automatic level_pair_type next_levels(input cv_item_type cv);
      level_pair_type lv;
      lv.level_a = advance_voice(0, cv.pitch_cv_a, cv.duty_cv_a);
      lv.level_b = advance_voice(1, cv.pitch_cv_b, cv.duty_cv_b);
      return lv;
   endfunction

   function automatic logic [15:0] random_cv(input int span);
      if ($urandom_range(99) < 30) return 16'($urandom);
      return 16'(int'($urandom_range(2 * span)) - span);
   endfunction

   task automatic report_mismatch(input string detail);
      $display("MISMATCH: %s", detail);
      mismatch_count++;
   endtask

   task automatic offer_cvs(input int pa, input int da, input int pb, input int db);
      cv_item_type cv;
      cv.pitch_cv_a = 16'(pa);
      cv.duty_cv_a  = 16'(da);
      cv.pitch_cv_b = 16'(pb);
      cv.duty_cv_b  = 16'(db);
      cv_backlog.push_back(cv);
      items_queued++;
   endtask

   task automatic write_reg(input logic [INDEX_BITS-1:0] index,
                            input logic [DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_voices(input logic [31:0] base, input logic [15:0] pka,
                             input logic [15:0] pkb, input logic [15:0] dka,
                             input logic [15:0] dkb);
      write_reg(dpwo_pkg::CSR_BASE_INC, base);
      write_reg(dpwo_pkg::CSR_PITCH_KNOB_A, 32'(pka));
      write_reg(dpwo_pkg::CSR_PITCH_KNOB_B, 32'(pkb));
      write_reg(dpwo_pkg::CSR_DUTY_KNOB_A, 32'(dka));
      write_reg(dpwo_pkg::CSR_DUTY_KNOB_B, 32'(dkb));
   endtask

   task automatic drain();
      do @(negedge clock); while (items_taken != items_queued || level_forecast.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int items, input int pct, input bit hold_rsp);
      @(posedge clock);
      idle_pct = pct;
      if (hold_rsp) rsp_holds_asked++;
      for (int i = 0; i < items; i++)
         offer_cvs(random_cv(6144), random_cv(10240), random_cv(6144), random_cv(10240));
      drain();
   endtask

   // sender: hold an item until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (cv_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= cv_backlog.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_holds_done < rsp_holds_asked) begin
         rsp_holds_done++;
         hold_left = RSP_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      level_pair_type due;
      if (reset) begin
         restore_power_on();
         req_took = 1'b0;
      end else begin
         req_took = req_tvalid && req_tready;
         if (csr_valid && csr_ready) load_register(csr_index, csr_data);
         if (req_took) begin
            level_forecast.push_back(next_levels(req_tdata));
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (level_forecast.size() == 0) begin
               report_mismatch($sformatf("item %0d returned with nothing pending",
                                         results_seen));
            end else begin
               due = level_forecast.pop_front();
               if (rsp_tdata[0] !== due.level_a)
                  report_mismatch($sformatf("item %0d level_a got %b want %b",
                                            results_seen, rsp_tdata[0], due.level_a));
               if (rsp_tdata[1] !== due.level_b)
                  report_mismatch($sformatf("item %0d level_b got %b want %b",
                                            results_seen, rsp_tdata[1], due.level_b));
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      build_pow2_table();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on settings: saturation, clamps, truncation toward zero
      offer_cvs(0, 0, 0, 0);
      offer_cvs(32767, 32767, -32768, -32768);
      offer_cvs(-32768, -32768, 32767, 32767);
      offer_cvs(24576, -1, -24576, 1);
      offer_cvs(24575, 10040, -24575, -10040);
      offer_cvs(2048, 0, -2048, 0);
      offer_cvs(1, -4, -1, 4);
      offer_cvs(16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
      offer_cvs(16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555);
      for (int i = 0; i < 12; i++)
         offer_cvs(i * 2048 - 12288, i * 2048 - 10240, 12288 - i * 2048, 10240 - i * 2048);
      run_phase(PHASE_ITEMS, IDLE_PCT, 1'b0);

      set_voices(32'hFFFF_FFFF, 16'sd16384, -16'sd16384, 16'd655, 16'd64880);
      run_phase(PHASE_ITEMS, 0, 1'b1);

      set_voices(32'd0, -16'sd16384, 16'sd16384, 16'd64880, 16'd655);
      run_phase(PHASE_ITEMS, IDLE_PCT, 1'b0);

      set_voices(32'd1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
      run_phase(PHASE_ITEMS, IDLE_PCT, 1'b0);

      // spare indexes must leave every register alone
      set_voices(dpwo_pkg::BASE_INC_RST, 16'sd4096, -16'sd4096, 16'd16384, 16'd49152);
      write_reg(CSR_SPARE_LOW, '1);
      write_reg(CSR_SPARE_TOP, '1);
      run_phase(PHASE_ITEMS, IDLE_PCT, 1'b0);

      for (int p = 0; p < 4; p++) begin
         set_voices((p % 2 == 0) ? $urandom : $urandom_range(67108864),
                    16'(int'($urandom_range(32768)) - 16384),
                    16'(int'($urandom_range(32768)) - 16384),
                    16'($urandom_range(64880, 655)), 16'($urandom_range(64880, 655)));
         run_phase(PHASE_ITEMS, IDLE_PCT, 1'b0);
      end

      if (level_forecast.size() != 0)
         report_mismatch($sformatf("%0d items never returned", level_forecast.size()));
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
